### hdl/srtf_tick_scheduler_core_macros.svh
// Assertion macros for the scheduler core.
`ifndef SRTF_TICK_SCHEDULER_CORE_MACROS_SVH
`define SRTF_TICK_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define SRTF_ASSERT_HOLDS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("srtf: invariant violated");

// cons must hold in the cycle after ante
`define SRTF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srtf: sequence violated");

`else

`define SRTF_ASSERT_HOLDS(lbl, clk, rst, expr)
`define SRTF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/srtf_pkg.sv
package srtf_pkg;

  localparam int IDX_W = 8;  // slot index, up to 256 slots
  localparam int CNT_W = 9;  // slot count, 0..256

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst_len;
  } in_item_t;

  typedef struct packed {
    logic        idle;
    logic [7:0]  run_id;
    logic        segment_start;
    logic [15:0] tick_time;
    logic        finished;
    logic [15:0] finish_time;
    logic        all_done;
  } out_item_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [15:0]      rem;
    logic [IDX_W-1:0] idx;
    logic [7:0]       id;
    logic [CNT_W-1:0] ndone;
  } link_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             load;
    logic             dec;
    logic [IDX_W-1:0] idx;
    logic [7:0]       proc_id;
    logic [15:0]      arrival;
    logic [15:0]      burst_len;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

endpackage

### hdl/srtf_cell.sv
module srtf_cell #(
  parameter int INDEX     = 0,
  parameter int TIME_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  srtf_pkg::cell_cmd_t      cmd,
  input  logic [TIME_BITS-1:0]     now,
  input  logic [srtf_pkg::CNT_W-1:0] n_use,
  input  srtf_pkg::link_t          lnk_in,
  output srtf_pkg::link_t          lnk_out
);
  import srtf_pkg::*;

  logic [7:0]  id;
  logic [15:0] arrival;
  logic [15:0] rem;
  logic        done;

  logic    hit;
  logic    in_use;
  logic    eligible;
  logic    take;
  link_t   lnk_next;

  assign hit      = (cmd.idx == IDX_W'(INDEX));
  assign in_use   = (CNT_W'(INDEX) < n_use);
  assign eligible = in_use && !done && (rem != 16'd0) &&
                    (32'(arrival) <= 32'(now));
  // strict compare keeps the lower slot on a tie
  assign take     = eligible && (!lnk_in.found || (rem < lnk_in.rem));

  always_comb begin
    lnk_next       = lnk_in;
    if (take) begin
      lnk_next.found = 1'b1;
      lnk_next.rem   = rem;
      lnk_next.idx   = IDX_W'(INDEX);
      lnk_next.id    = id;
    end
    lnk_next.ndone = lnk_in.ndone + CNT_W'(in_use && done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lnk_out.found <= 1'b0;
      lnk_out.ndone <= '0;
    end else begin
      lnk_out.found <= lnk_next.found;
      lnk_out.ndone <= lnk_next.ndone;
    end
    lnk_out.rem <= lnk_next.rem;
    lnk_out.idx <= lnk_next.idx;
    lnk_out.id  <= lnk_next.id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (hit && cmd.load) begin
      done <= (cmd.burst_len == 16'd0);
    end else if (hit && cmd.dec) begin
      done <= (rem == 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.load) begin
      id      <= cmd.proc_id;
      arrival <= cmd.arrival;
      rem     <= cmd.burst_len;
    end else if (hit && cmd.dec) begin
      rem <= rem - 16'd1;
    end
  end

endmodule

### hdl/srtf_tick_scheduler_core.sv
// Channel   Handshake                  Payload
// in        in_valid / in_ready        in_data  (in_item_t)
// out       out_valid / out_ready      out_data (out_item_t)
// cfg       cfg_we                     cfg_wdata (process_count)
//
// A load transaction gives no result.
// A tick transaction walks the candidate along the row of slot cells, one
// cell a cycle, then the pick is committed.
// Reset (rst, synchronous) clears done flags, time, last id and counters.
// The output register frees the scan from the consumer; a tick whose
// result cannot be stored holds until out_ready.
`include "srtf_tick_scheduler_core_macros.svh"

module srtf_tick_scheduler_core #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srtf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srtf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);
  import srtf_pkg::*;

  localparam int SCAN_W = $clog2(MAX_PROCS + 2);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(MAX_PROCS);

  logic [4:0]           process_count;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] now_inc;
  logic [31:0]          now_w;
  logic [31:0]          now_inc_w;
  logic [7:0]           last_id;
  logic                 last_valid;
  logic [SCAN_W-1:0]    scan_cnt;
  state_t               state;
  state_t               state_next;

  logic                 in_fire;
  logic                 scan_end;
  logic                 commit;
  logic                 all_prev;
  logic                 run;
  logic [CNT_W-1:0]     n_use;
  cell_cmd_t            cmd;
  out_item_t            res;
  link_t                lnk [MAX_PROCS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= 5'd0;
    end else if (cfg_we) begin
      process_count <= cfg_wdata;
    end
  end

  assign n_use = (32'(process_count) > 32'(MAX_PROCS)) ? CNT_W'(MAX_PROCS)
                                                       : CNT_W'(process_count);

  // seed of the row: nothing found, nothing counted
  assign lnk[0] = '0;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    srtf_cell #(
      .INDEX     (i),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .now     (now),
      .n_use   (n_use),
      .lnk_in  (lnk[i]),
      .lnk_out (lnk[i+1])
    );
  end

  // state machine: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_data.kind == KIND_TICK) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = commit ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_ready = 1'b0;
    scan_end = 1'b0;
    commit   = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: begin
        scan_end = (scan_cnt == SCAN_LAST);
        commit   = scan_end && (!out_valid || out_ready);
      end
      ST_WAIT: commit = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN && !scan_end) begin
        scan_cnt <= scan_cnt + SCAN_W'(1);
      end else if (state == ST_IDLE) begin
        scan_cnt <= '0;
      end
    end
  end

  // result of the walk, read off the last cell
  assign all_prev  = (lnk[MAX_PROCS].ndone == n_use);
  assign run       = !all_prev && lnk[MAX_PROCS].found;
  assign now_inc   = (now == '1) ? now : now + TIME_BITS'(1);
  assign now_w     = 32'(now);
  assign now_inc_w = 32'(now_inc);

  always_comb begin
    res           = '0;
    res.tick_time = now_w[15:0];
    if (all_prev) begin
      res.idle     = 1'b1;
      res.all_done = 1'b1;
    end else if (!run) begin
      res.idle = 1'b1;
    end else begin
      res.run_id        = lnk[MAX_PROCS].id;
      res.segment_start = !last_valid || (last_id != lnk[MAX_PROCS].id);
      res.finished      = (lnk[MAX_PROCS].rem == 16'd1);
      res.finish_time   = res.finished ? now_inc_w[15:0] : 16'd0;
      res.all_done      = res.finished &&
                          ((lnk[MAX_PROCS].ndone + CNT_W'(1)) == n_use);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = in_fire && (in_data.kind == KIND_LOAD) &&
                    (32'(in_data.slot) < 32'(MAX_PROCS));
    cmd.proc_id   = in_data.proc_id;
    cmd.arrival   = in_data.arrival;
    cmd.burst_len = in_data.burst_len;
    if (cmd.load) begin
      cmd.idx = IDX_W'(in_data.slot);
    end else begin
      cmd.idx = lnk[MAX_PROCS].idx;
    end
    cmd.dec = commit && run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      last_id    <= 8'd0;
      last_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
        if (!all_prev) now <= now_inc;
        if (run) begin
          last_id    <= lnk[MAX_PROCS].id;
          last_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) out_data <= res;
  end

  `SRTF_ASSERT_NEXT(a_commit_shows, clk, rst, commit, out_valid)
  `SRTF_ASSERT_HOLDS(a_count_bound, clk, rst, !scan_end || (lnk[MAX_PROCS].ndone <= n_use))
  `SRTF_ASSERT_HOLDS(a_finish_runs, clk, rst, !out_valid || !(out_data.finished && out_data.idle))
  `SRTF_ASSERT_HOLDS(a_dec_one_cell, clk, rst, !(cmd.dec && cmd.load))

endmodule
